FILE: rtl/big5_char_type_classifier_macros.svh
// Assertion helpers for the Big5 character classifier.
`ifndef BIG5_CHAR_TYPE_CLASSIFIER_MACROS_SVH
`define BIG5_CHAR_TYPE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define B5CC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define B5CC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/b5cc_pkg.sv
package b5cc_pkg;

   // Character classes, shared by prev_type and char_class
   localparam logic [2:0] CLS_OTHER  = 3'd0;
   localparam logic [2:0] CLS_LETTER = 3'd1;
   localparam logic [2:0] CLS_NUMBER = 3'd2;
   localparam logic [2:0] CLS_PUNCT  = 3'd3;
   localparam logic [2:0] CLS_SPACE  = 3'd4;
   localparam logic [2:0] CLS_DATE   = 3'd5;

   localparam logic [1:0] LEN_NUL  = 2'd0;
   localparam logic [1:0] LEN_BYTE = 2'd1;
   localparam logic [1:0] LEN_WIDE = 2'd2;

   // Big5 characters that take part in context rules
   localparam logic [15:0] CH_ZHI   = 16'ha4a7;
   localparam logic [15:0] CH_DIAN  = 16'hc249;
   localparam logic [15:0] CH_FEN   = 16'ha4c0;
   localparam logic [15:0] CH_DUO   = 16'ha668;
   localparam logic [15:0] CH_YU    = 16'ha745;
   localparam logic [15:0] CH_CHENG = 16'ha6a8;
   localparam logic [15:0] CH_BAN   = 16'ha562;

   localparam logic [7:0] ASC_DOT    = 8'h2e;
   localparam logic [7:0] ASC_COMMA  = 8'h2c;
   localparam logic [7:0] ASC_HYPHEN = 8'h2d;
   localparam logic [7:0] ASC_PCT    = 8'h25;

   localparam int NUM_NUMERALS = 19;
   localparam int NUM_DATES    = 7;

   localparam logic [15:0] NUMERAL_CODES [NUM_NUMERALS] = '{
      16'ha1b3, 16'ha144, 16'ha248,
      16'hb973, 16'ha440, 16'ha447, 16'ha454, 16'ha57c,
      16'ha4ad, 16'ha4bb, 16'ha443, 16'ha44b, 16'ha445,
      16'ha451, 16'ha6ca, 16'ha464, 16'hb855, 16'hbbf5,
      16'ha8e2
   };

   localparam logic [15:0] DATE_CODES [NUM_DATES] = '{
      16'ha67e, 16'ha4eb, 16'ha4e9, 16'haec9, 16'ha4c0, 16'haced, 16'hc249
   };

   typedef struct packed {
      logic [7:0] cur_lead;
      logic [7:0] cur_trail;
      logic       next_present;
      logic [7:0] next_lead;
      logic [7:0] next_trail;
      logic [2:0] prev_type;
   } req_type;

   typedef struct packed {
      logic [2:0] char_class;
      logic [1:0] byte_length;
   } rsp_type;

   function automatic logic is_letter(input logic [7:0] lead, input logic [7:0] trail);
      if (!lead[7]) begin
         return (lead >= 8'h41 && lead <= 8'h5a) || (lead >= 8'h61 && lead <= 8'h7a);
      end
      return (lead == 8'ha2 && trail >= 8'hcf && trail <= 8'hfe) ||
             (lead == 8'ha3 && trail >= 8'h40 && trail <= 8'h43);
   endfunction

   function automatic logic is_digit(input logic [7:0] lead, input logic [7:0] trail);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_NUMERALS; i++) begin
         if ({lead, trail} == NUMERAL_CODES[i]) hit = 1'b1;
      end
      if ((lead >= 8'h30 && lead <= 8'h39) || lead == ASC_PCT) begin
         return 1'b1;
      end
      if (!lead[7]) begin
         return 1'b0;
      end
      return (lead == 8'ha2 && trail >= 8'haf && trail <= 8'hb8) || hit;
   endfunction

   function automatic logic is_punct(input logic [7:0] lead, input logic [7:0] trail);
      if (lead == ASC_DOT || lead == ASC_COMMA) begin
         return 1'b0;
      end
      if (!lead[7]) begin
         return (lead >= 8'h21 && lead <= 8'h2f) || (lead >= 8'h3a && lead <= 8'h40) ||
                (lead >= 8'h5b && lead <= 8'h60) || (lead >= 8'h7b && lead <= 8'h7e);
      end
      if (lead == 8'ha1) begin
         return (trail >= 8'h41 && trail <= 8'h7e) || (trail >= 8'ha1 && trail <= 8'hb2) ||
                (trail >= 8'hb4 && trail <= 8'hfe);
      end
      if (lead == 8'ha2) begin
         return (trail >= 8'h40 && trail <= 8'h7e) || (trail >= 8'ha1 && trail <= 8'hae);
      end
      return 1'b0;
   endfunction

   function automatic logic is_space(input logic [7:0] lead, input logic [7:0] trail);
      if (!lead[7]) begin
         return lead == 8'h20 || (lead >= 8'h09 && lead <= 8'h0d);
      end
      return lead == 8'ha1 && trail == 8'h40;
   endfunction

   function automatic logic is_date(input logic [7:0] lead, input logic [7:0] trail);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_DATES; i++) begin
         if ({lead, trail} == DATE_CODES[i]) hit = 1'b1;
      end
      return lead[7] && hit;
   endfunction

   function automatic logic [1:0] char_len(input logic [7:0] lead);
      if (lead == 8'h00) begin
         return LEN_NUL;
      end
      return lead[7] ? LEN_WIDE : LEN_BYTE;
   endfunction

endpackage

FILE: rtl/big5_char_type_classifier.sv
// Big5 / ASCII character classifier for a word segmentation front end.
//
// Request channel (req_*): one character per request - lead and trail
// byte, an optional following character and the class of the character
// before it. Response channel (rsp_*): the character's class (other,
// letter, number, punctuation, space, date) and its length in bytes.
// Both channels move a request on a clock edge with valid high and stall low.
//
// Path: a taken request lands in the input register, is classified
// combinationally from it, and moves on to the result register and rsp_*
// when that register is free. Throughput: one request per cycle unless a
// stall holds it back; the input and result registers form a two-deep
// pipeline: a new request is taken while the previous result waits on rsp_*.
// When rsp_stall is high with a result held, the result stays put; the
// input register can still fill once, after which req_stall rises in the
// same cycle (combinational from rsp_stall) until the result moves.
// Reset (synchronous, active high) empties both stages, dropping any
// request they hold; the block holds no other state.
`include "big5_char_type_classifier_macros.svh"

module big5_char_type_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b5cc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b5cc_pkg::rsp_type rsp_data
);
   import b5cc_pkg::*;

   // stage 1: captured request
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   // stage 2: result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic out_move;   // result register may load this cycle
   logic in_take;    // input register may load this cycle

   assign out_move  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_move;
   assign in_take   = !req_stall;

   assign out_valid_in = out_move ? in_valid_ff : out_valid_ff;
   assign in_valid_in  = in_take ? req_valid : in_valid_ff;

   // Classification of the captured request
   logic [7:0]  lead, trail, nlead, ntrail;
   logic [15:0] code;
   logic        prev_num, prev_alnum, next_digit, next_alnum;
   logic        ctx_hit;
   logic [2:0]  ctx_class, cls;

   always_comb begin
      lead   = in_data_ff.cur_lead;
      trail  = in_data_ff.cur_trail;
      nlead  = in_data_ff.next_lead;
      ntrail = in_data_ff.next_trail;
      code   = {lead, trail};

      prev_num   = in_data_ff.prev_type == CLS_NUMBER;
      prev_alnum = prev_num || in_data_ff.prev_type == CLS_LETTER;
      next_digit = in_data_ff.next_present && is_digit(nlead, ntrail);
      next_alnum = in_data_ff.next_present &&
                   (is_letter(nlead, ntrail) || is_digit(nlead, ntrail));

      // Context rules; the Big5 constants all have a high lead byte, so a
      // 16-bit match already implies a double-byte character.
      ctx_hit   = 1'b0;
      ctx_class = CLS_OTHER;
      if (lead == ASC_DOT || lead == ASC_HYPHEN) begin
         ctx_hit   = 1'b1;
         ctx_class = (prev_alnum && next_alnum) ? CLS_LETTER : CLS_PUNCT;
      end else if (lead == ASC_COMMA) begin
         ctx_hit   = 1'b1;
         ctx_class = (prev_num && next_digit) ? CLS_LETTER : CLS_PUNCT;
      end else if (code == CH_ZHI || code == CH_DIAN || code == CH_CHENG ||
                   code == CH_BAN) begin
         ctx_hit   = prev_num && next_digit;
         ctx_class = CLS_NUMBER;
      end else if (code == CH_FEN) begin
         // "fen zhi" (fraction marker) reads as a number
         ctx_hit   = in_data_ff.next_present && {nlead, ntrail} == CH_ZHI;
         ctx_class = CLS_NUMBER;
      end else if (code == CH_DUO || code == CH_YU) begin
         ctx_hit   = prev_num;
         ctx_class = CLS_NUMBER;
      end

      // Fixed tables in priority order
      if (ctx_hit) begin
         cls = ctx_class;
      end else if (is_letter(lead, trail)) begin
         cls = CLS_LETTER;
      end else if (is_digit(lead, trail)) begin
         cls = CLS_NUMBER;
      end else if (is_punct(lead, trail)) begin
         cls = CLS_PUNCT;
      end else if (is_space(lead, trail)) begin
         cls = CLS_SPACE;
      end else if (is_date(lead, trail)) begin
         cls = prev_num ? CLS_DATE : CLS_OTHER;
      end else begin
         cls = CLS_OTHER;
      end

      out_data_in.char_class  = cls;
      out_data_in.byte_length = char_len(lead);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (in_take) begin
         in_data_ff <= req_data;
      end
      if (out_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `B5CC_ASSERT_NEXT(a_take_fills, req_valid && !req_stall, in_valid_ff, "accepted request not captured")
   `B5CC_ASSERT_NOW(a_stall_only_full, req_stall, in_valid_ff && out_valid_ff, "stall without full pipeline")
   `B5CC_ASSERT_NEXT(a_move_fills, in_valid_ff && out_move, rsp_valid, "captured request did not reach result")
   `B5CC_ASSERT_NEXT(a_len_follows, in_valid_ff && out_move, rsp_data.byte_length == char_len($past(in_data_ff.cur_lead)), "length mismatch")
   `B5CC_ASSERT_NOW(a_nul_other, rsp_valid && rsp_data.byte_length == LEN_NUL, rsp_data.char_class == CLS_OTHER, "NUL not classed as other")

endmodule

FILE: tb/big5_char_type_classifier_tb.sv
`timescale 1ns / 1ps

module big5_char_type_classifier_tb;
   import b5cc_pkg::*;

   // Watchdog: cycles without any accepted request or result before giving up.
   // Worst legal gap is a long sender idle run or the response hold-off,
   // so this leaves a wide margin.
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 40;   // length of the forced response hold-off
   localparam int MAX_REPORTS = 10;

   // Big5 numerals that count as numbers on their own
   localparam logic [15:0] NUMERAL_LIST [19] = '{
      16'ha1b3, 16'ha144, 16'ha248,
      16'hb973, 16'ha440, 16'ha447, 16'ha454, 16'ha57c,
      16'ha4ad, 16'ha4bb, 16'ha443, 16'ha44b, 16'ha445,
      16'ha451, 16'ha6ca, 16'ha464, 16'hb855, 16'hbbf5,
      16'ha8e2
   };

   // Big5 characters that mark a date when a number comes first
   localparam logic [15:0] DATE_LIST [7] = '{
      16'ha67e, 16'ha4eb, 16'ha4e9, 16'haec9, 16'ha4c0, 16'haced, 16'hc249
   };

   // Big5 characters with context rules
   localparam logic [15:0] CONTEXT_LIST [7] = '{
      CH_ZHI, CH_DIAN, CH_FEN, CH_DUO, CH_YU, CH_CHENG, CH_BAN
   };

   // ASCII bytes worth hitting often: context marks, percent, NUL, blank
   localparam logic [7:0] ASCII_MARKS [6] = '{
      ASC_DOT, ASC_COMMA, ASC_HYPHEN, ASC_PCT, 8'h00, 8'h20
   };

   // ------------------------------------------------------------------
   // Scoreboard: predicts the class and length of every accepted request
   // and checks results in order against those predictions.
   // ------------------------------------------------------------------
   class char_class_scoreboard;
      rsp_type     predicted_q[$];
      int unsigned requests_seen;
      int unsigned results_seen;
      int unsigned mismatches;

      function bit alpha_char(logic [7:0] lead, logic [7:0] trail);
         if (!lead[7]) begin
            return (lead >= 8'h41 && lead <= 8'h5a) || (lead >= 8'h61 && lead <= 8'h7a);
         end
         return (lead == 8'ha2 && trail >= 8'hcf && trail <= 8'hfe) ||
                (lead == 8'ha3 && trail >= 8'h40 && trail <= 8'h43);
      endfunction

      function bit numeral_char(logic [7:0] lead, logic [7:0] trail);
         bit hit;
         hit = 1'b0;
         if ((lead >= 8'h30 && lead <= 8'h39) || lead == ASC_PCT) begin
            return 1'b1;
         end
         if (!lead[7]) begin
            return 1'b0;
         end
         if (lead == 8'ha2 && trail >= 8'haf && trail <= 8'hb8) begin
            return 1'b1;
         end
         foreach (NUMERAL_LIST[i]) begin
            if (NUMERAL_LIST[i] == {lead, trail}) hit = 1'b1;
         end
         return hit;
      endfunction

      function rsp_type classify_char(req_type r);
         rsp_type     res;
         logic [7:0]  lead;
         logic [7:0]  trail;
         logic [15:0] code;
         bit          prev_num, prev_alnum, next_digit, next_alnum;
         bit          settled, mark, blank, dated;
         lead       = r.cur_lead;
         trail      = r.cur_trail;
         code       = lead[7] ? {lead, trail} : {8'h00, lead};
         prev_num   = (r.prev_type == CLS_NUMBER);
         prev_alnum = prev_num || (r.prev_type == CLS_LETTER);
         next_digit = r.next_present && numeral_char(r.next_lead, r.next_trail);
         next_alnum = next_digit ||
                      (r.next_present && alpha_char(r.next_lead, r.next_trail));
         settled    = 1'b1;
         res.char_class = CLS_OTHER;

         // context rules first
         case (code)
            {8'h00, ASC_DOT}, {8'h00, ASC_HYPHEN}: begin
               res.char_class = (prev_alnum && next_alnum) ? CLS_LETTER : CLS_PUNCT;
            end
            {8'h00, ASC_COMMA}: begin
               res.char_class = (prev_num && next_digit) ? CLS_LETTER : CLS_PUNCT;
            end
            CH_ZHI, CH_DIAN, CH_CHENG, CH_BAN: begin
               settled = prev_num && next_digit;
               res.char_class = CLS_NUMBER;
            end
            CH_FEN: begin
               settled = r.next_present && r.next_lead[7] &&
                         ({r.next_lead, r.next_trail} == CH_ZHI);
               res.char_class = CLS_NUMBER;
            end
            CH_DUO, CH_YU: begin
               settled = prev_num;
               res.char_class = CLS_NUMBER;
            end
            default: begin
               settled = 1'b0;
            end
         endcase

         // fixed tables
         if (!settled) begin
            if (!lead[7]) begin
               mark = lead != ASC_DOT && lead != ASC_COMMA &&
                      ((lead >= 8'h21 && lead <= 8'h2f) || (lead >= 8'h3a && lead <= 8'h40) ||
                       (lead >= 8'h5b && lead <= 8'h60) || (lead >= 8'h7b && lead <= 8'h7e));
               blank = lead == 8'h20 || (lead >= 8'h09 && lead <= 8'h0d);
            end else begin
               mark = (lead == 8'ha1 &&
                       ((trail >= 8'h41 && trail <= 8'h7e) || (trail >= 8'ha1 && trail <= 8'hb2) ||
                        (trail >= 8'hb4 && trail <= 8'hfe))) ||
                      (lead == 8'ha2 &&
                       ((trail >= 8'h40 && trail <= 8'h7e) || (trail >= 8'ha1 && trail <= 8'hae)));
               blank = lead == 8'ha1 && trail == 8'h40;
            end
            dated = 1'b0;
            foreach (DATE_LIST[i]) begin
               if (lead[7] && DATE_LIST[i] == code) dated = 1'b1;
            end
            if (alpha_char(lead, trail)) res.char_class = CLS_LETTER;
            else if (numeral_char(lead, trail)) res.char_class = CLS_NUMBER;
            else if (mark) res.char_class = CLS_PUNCT;
            else if (blank) res.char_class = CLS_SPACE;
            else if (dated) res.char_class = prev_num ? CLS_DATE : CLS_OTHER;
            else res.char_class = CLS_OTHER;
         end

         if (lead == 8'h00) res.byte_length = LEN_NUL;
         else if (lead[7]) res.byte_length = LEN_WIDE;
         else res.byte_length = LEN_BYTE;
         return res;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
      endfunction

      function void note_request(req_type r);
         requests_seen++;
         predicted_q.push_back(classify_char(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (predicted_q.size() == 0) begin
            flag($sformatf("unexpected result: class %0d length %0d",
                           got.char_class, got.byte_length));
            return;
         end
         want = predicted_q.pop_front();
         if (got.char_class !== want.char_class || got.byte_length !== want.byte_length) begin
            flag($sformatf("mismatch: expected class %0d length %0d, got class %0d length %0d",
                           want.char_class, want.byte_length, got.char_class, got.byte_length));
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   big5_char_type_classifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   char_class_scoreboard sb = new();

   // Idle mix, changed by the main sequence between phases
   int unsigned req_idle_pct = 21;
   int unsigned rsp_idle_pct = 69;

   // Hold-off handshake: main bumps holds_requested, the response side
   // serves it by holding rsp_stall high for a hold-off that it counts itself.
   int unsigned holds_requested = 0;
   int unsigned holds_served    = 0;
   int unsigned hold_left       = 0;

   // Response side: random stall per cycle, or a long hold when asked.
   always @(posedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Monitor: values read here are the ones that were stable before the edge,
   // since every TB drive and every DUT register update is nonblocking.
   // Results are checked before the same-edge request is noted, so a result
   // can never pair with a request taken on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   // Watchdog: any accepted request or result restarts the count.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results still expected",
                  IDLE_LIMIT, sb.predicted_q.size());
         $display("big5_char_type_classifier_tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic req_type mk(logic [7:0] lead, logic [7:0] trail, logic np,
                                  logic [7:0] nlead, logic [7:0] ntrail, logic [2:0] prev);
      req_type r;
      r.cur_lead     = lead;
      r.cur_trail    = trail;
      r.next_present = np;
      r.next_lead    = nlead;
      r.next_trail   = ntrail;
      r.prev_type    = prev;
      return r;
   endfunction

   // One character as {lead, trail}; biased toward the interesting corners.
   // The trail byte stays random for ASCII picks so it gets exercised too.
   function automatic logic [15:0] pick_char();
      logic [15:0] c;
      c = 16'($urandom());
      case ($urandom_range(9))
         0: c[15:8] = 8'($urandom_range(127));
         1: c[15:8] = ASCII_MARKS[$urandom_range(5)];
         2: c[15:8] = $urandom_range(1) ? 8'($urandom_range(8'h30, 8'h39))
                                        : 8'($urandom_range(8'h41, 8'h7a));
         3: c = CONTEXT_LIST[$urandom_range(6)];
         4: c = NUMERAL_LIST[$urandom_range(18)];
         5: c = DATE_LIST[$urandom_range(6)];
         6, 7: c[15:8] = 8'($urandom_range(8'ha1, 8'ha3));
         default: ;
      endcase
      return c;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      logic [15:0] cur;
      logic [15:0] nxt;
      cur = pick_char();
      nxt = pick_char();
      r.cur_lead     = cur[15:8];
      r.cur_trail    = cur[7:0];
      r.next_present = ($urandom_range(3) != 0);
      r.next_lead    = nxt[15:8];
      r.next_trail   = nxt[7:0];
      // context rules want a number or letter before; unused codes 6 and 7 too
      case ($urandom_range(3))
         0: r.prev_type = CLS_NUMBER;
         1: r.prev_type = CLS_LETTER;
         default: r.prev_type = 3'($urandom_range(7));
      endcase
      return r;
   endfunction

   // Offer one request and return on the edge that takes it. An idle run,
   // if any, comes first; valid stays high when the next request follows
   // straight on, so it is never dropped and raised within one step.
   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct && gap < 60) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_request(random_request());
   endtask

   // Stop offering and wait for every predicted result to come back.
   // It first waits for a clock edge so the monitor has noted the last accepted request.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.predicted_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Phase 1: sender idles 21%, receiver 69%. Directed corners first.
      send_request(mk(8'h00, 8'h55, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // NUL
      send_request(mk(8'h7f, 8'hff, 1'b1, 8'hff, 8'hff, 3'd7));           // DEL, top ASCII
      send_request(mk(8'hff, 8'hff, 1'b1, 8'h00, 8'h00, CLS_NUMBER));     // top Big5 code
      send_request(mk(8'h41, 8'hff, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // letter, trail ignored
      send_request(mk(8'h7a, 8'h00, 1'b1, 8'h30, 8'h00, CLS_LETTER));
      send_request(mk(8'h39, 8'ha4, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // digit
      send_request(mk(ASC_PCT, 8'h00, 1'b0, 8'h00, 8'h00, CLS_OTHER));    // percent is a number
      send_request(mk(ASC_DOT, 8'h00, 1'b1, 8'h61, 8'hff, CLS_NUMBER));   // dot inside alnum
      send_request(mk(ASC_DOT, 8'h00, 1'b1, 8'h61, 8'h00, 3'd6));         // unused prev code
      send_request(mk(ASC_HYPHEN, 8'h00, 1'b0, 8'h41, 8'h00, CLS_LETTER)); // no next char
      send_request(mk(ASC_COMMA, 8'h00, 1'b1, 8'h35, 8'h00, CLS_NUMBER)); // thousands comma
      send_request(mk(ASC_COMMA, 8'h00, 1'b1, 8'h35, 8'h00, CLS_LETTER)); // comma after letter
      send_request(mk(CH_ZHI[15:8], CH_ZHI[7:0], 1'b1, 8'ha4, 8'h40, CLS_NUMBER));
      send_request(mk(CH_ZHI[15:8], CH_ZHI[7:0], 1'b0, 8'ha4, 8'h40, CLS_NUMBER));
      send_request(mk(CH_FEN[15:8], CH_FEN[7:0], 1'b1, CH_ZHI[15:8], CH_ZHI[7:0], CLS_OTHER));
      send_request(mk(CH_FEN[15:8], CH_FEN[7:0], 1'b0, CH_ZHI[15:8], CH_ZHI[7:0], CLS_NUMBER));
      send_request(mk(CH_DUO[15:8], CH_DUO[7:0], 1'b0, 8'h00, 8'h00, CLS_NUMBER));
      send_request(mk(CH_YU[15:8], CH_YU[7:0], 1'b0, 8'h00, 8'h00, CLS_OTHER));
      send_request(mk(CH_DIAN[15:8], CH_DIAN[7:0], 1'b1, 8'h41, 8'h00, CLS_NUMBER)); // date
      send_request(mk(8'ha6, 8'h7e, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // date, no number before
      send_request(mk(8'ha1, 8'h40, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // ideographic space
      send_request(mk(8'ha1, 8'hff, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // just past punct range
      send_request(mk(8'ha1, 8'hb3, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // numeral in punct row
      send_request(mk(8'ha2, 8'hcf, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // fullwidth letter
      send_request(mk(8'h09, 8'h20, 1'b0, 8'h00, 8'h00, CLS_OTHER));      // tab
      send_random(150);

      // Phase 2: the other way round.
      req_idle_pct <= 69;
      rsp_idle_pct <= 21;
      send_random(170);

      // Phase 3: no idling. A long response hold fills the pipeline and
      // backs up the request side while requests keep coming.
      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      holds_requested <= holds_requested + 1;
      send_random(20);
      // Pause until every result is back, then carry on.
      drain();
      repeat ($urandom_range(3, 12)) @(posedge clock);
      send_random(140);

      // Wind down: wait for the tail, then watch for stray results.
      drain();
      repeat (4) @(posedge clock);

      $display("covered %0d requests and %0d results over three idle mixes,",
               sb.requests_seen, sb.results_seen);
      $display("including a %0d-cycle response hold and a full drain pause",
               HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.predicted_q.size() == 0) begin
         $display("big5_char_type_classifier_tb: PASS");
      end else begin
         $display("%0d mismatches, %0d results never came",
                  sb.mismatches, sb.predicted_q.size());
         $display("big5_char_type_classifier_tb: FAIL");
      end
      $finish;
   end

endmodule
